// ===== rtl/core/pacf_pkg.sv =====
`timescale 1ns / 1ps
// pacf_pkg: shared types and constants of the point attribute and clip filter
// used by pacf_datapath, point_attribute_clip_filter and pacf_checker

package pacf_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned ReasonW = 2;

  typedef enum logic [2:0] {
    ATTR_NONE      = 3'd0,
    ATTR_BELOW     = 3'd1,
    ATTR_BELOW_EQ  = 3'd2,
    ATTR_ABOVE     = 3'd3,
    ATTR_ABOVE_EQ  = 3'd4,
    ATTR_BETWEEN   = 3'd5,
    ATTR_EQUAL     = 3'd6,
    ATTR_DIFFERENT = 3'd7
  } attr_mode_e;

  typedef enum logic [1:0] {
    CLIP_NONE   = 2'd0,
    CLIP_RECT   = 2'd1,
    CLIP_CIRCLE = 2'd2
  } clip_mode_e;

  typedef enum logic [ReasonW-1:0] {
    REASON_KEPT = 2'd0,
    REASON_ATTR = 2'd1,
    REASON_CLIP = 2'd2
  } reason_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ATTR_MODE = 4'd0,
    CFG_BOUND_A   = 4'd1,
    CFG_BOUND_B   = 4'd2,
    CFG_CLIP_MODE = 4'd3,
    CFG_CLIP_XMIN = 4'd4,
    CFG_CLIP_YMIN = 4'd5,
    CFG_CLIP_XMAX = 4'd6,
    CFG_CLIP_YMAX = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    attr_mode_e        attr_mode;
    logic [CoordW-1:0] bound_a;
    logic [CoordW-1:0] bound_b;
    clip_mode_e        clip_mode;
    logic [CoordW-1:0] clip_xmin;
    logic [CoordW-1:0] clip_ymin;
    logic [CoordW-1:0] clip_xmax;
    logic [CoordW-1:0] clip_ymax;
  } cfg_t;

endpackage

// ===== rtl/core/pacf_datapath.sv =====
`timescale 1ns / 1ps
// pacf_datapath: five-stage pipeline that judges one point per cycle while the output is not stalled
// depends on pacf_pkg for the register set and the reason codes

module pacf_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pacf_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [31:0]            pos_x_i,
  input  logic [31:0]            pos_y_i,
  input  logic [31:0]            attr_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   keep_o,
  output logic [1:0]             reject_reason_o
);
  import pacf_pkg::*;

  localparam int unsigned SumW = CoordW + 2;
  localparam int unsigned SqW  = 2 * CoordW;

  // per-stage valid bits and advance enables
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic s1_en, s2_en, s3_en, s4_en, s5_en;

  assign s5_en = !s5_valid_q || out_ready_i;
  assign s4_en = !s4_valid_q || s5_en;
  assign s3_en = !s3_valid_q || s4_en;
  assign s2_en = !s2_valid_q || s3_en;
  assign s1_en = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  // stage 1: input capture
  logic signed [CoordW-1:0] x_q, y_q, v_q;

  // stage 2: attribute test, box test, centre offsets
  logic signed [CoordW-1:0] a_s, b_s, lo_s, hi_s;
  logic signed [CoordW-1:0] xmin_s, xmax_s, ymin_s, ymax_s;
  logic                     attr_fail_d, attr_fail2_q;
  logic                     box_out_d, box_out2_q;
  logic signed [SumW-1:0]   dx_d, dy_d, dx_q, dy_q;
  logic [SumW-1:0]          r_full;
  logic [CoordW-1:0]        r_d, r2_q;

  assign a_s    = $signed(cfg_i.bound_a);
  assign b_s    = $signed(cfg_i.bound_b);
  assign lo_s   = (a_s < b_s) ? a_s : b_s;
  assign hi_s   = (a_s < b_s) ? b_s : a_s;
  assign xmin_s = $signed(cfg_i.clip_xmin);
  assign xmax_s = $signed(cfg_i.clip_xmax);
  assign ymin_s = $signed(cfg_i.clip_ymin);
  assign ymax_s = $signed(cfg_i.clip_ymax);

  always_comb begin
    unique case (cfg_i.attr_mode)
      ATTR_BELOW:     attr_fail_d = !(v_q < a_s);
      ATTR_BELOW_EQ:  attr_fail_d = !(v_q <= a_s);
      ATTR_ABOVE:     attr_fail_d = !(v_q > a_s);
      ATTR_ABOVE_EQ:  attr_fail_d = !(v_q >= a_s);
      ATTR_BETWEEN:   attr_fail_d = !((v_q >= lo_s) && (v_q < hi_s));
      ATTR_EQUAL:     attr_fail_d = !(v_q == a_s);
      ATTR_DIFFERENT: attr_fail_d = !(v_q != a_s);
      default:        attr_fail_d = 1'b0;
    endcase
  end

  assign box_out_d = (x_q < xmin_s) || (x_q > xmax_s) || (y_q < ymin_s) || (y_q > ymax_s);

  // doubled offsets from the box centre
  assign dx_d   = SumW'(xmax_s) + SumW'(xmin_s) - (SumW'(x_q) <<< 1);
  assign dy_d   = SumW'(ymax_s) + SumW'(ymin_s) - (SumW'(y_q) <<< 1);
  // span is non-negative and below 2^32 whenever the point is inside the box
  assign r_full = SumW'(xmax_s) - SumW'(xmin_s);
  assign r_d    = r_full[CoordW-1:0];

  // stage 3: magnitudes, which fit 32 bits inside the box
  logic [SumW-1:0]   dx_mag, dy_mag;
  logic [CoordW-1:0] dx_abs_q, dy_abs_q, r3_q;
  logic              attr_fail3_q, box_out3_q;

  assign dx_mag = dx_q[SumW-1] ? SumW'(-dx_q) : SumW'(dx_q);
  assign dy_mag = dy_q[SumW-1] ? SumW'(-dy_q) : SumW'(dy_q);

  // stage 4: squares
  logic [SqW-1:0] dx_sq_d, dy_sq_d, r_sq_d;
  logic [SqW-1:0] dx_sq_q, dy_sq_q, r_sq_q;
  logic           attr_fail4_q, box_out4_q;

  assign dx_sq_d = dx_abs_q * dx_abs_q;
  assign dy_sq_d = dy_abs_q * dy_abs_q;
  assign r_sq_d  = r3_q * r3_q;

  // stage 5: circle compare and the verdict
  logic [SqW:0] dist_sq;
  logic         circ_out;
  logic         clip_fail;
  reason_e      reason_d, reason_q;

  assign dist_sq  = (SqW + 1)'(dx_sq_q) + (SqW + 1)'(dy_sq_q);
  assign circ_out = dist_sq > (SqW + 1)'(r_sq_q);

  always_comb begin
    case (cfg_i.clip_mode)
      CLIP_RECT:   clip_fail = box_out4_q;
      CLIP_CIRCLE: clip_fail = box_out4_q || circ_out;
      default:     clip_fail = 1'b0;
    endcase
    if (attr_fail4_q) begin
      reason_d = REASON_ATTR;
    end else if (clip_fail) begin
      reason_d = REASON_CLIP;
    end else begin
      reason_d = REASON_KEPT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
      if (s3_en) s3_valid_q <= s2_valid_q;
      if (s4_en) s4_valid_q <= s3_valid_q;
      if (s5_en) s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      x_q <= $signed(pos_x_i);
      y_q <= $signed(pos_y_i);
      v_q <= $signed(attr_value_i);
    end
    if (s2_en && s1_valid_q) begin
      attr_fail2_q <= attr_fail_d;
      box_out2_q   <= box_out_d;
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      r2_q         <= r_d;
    end
    if (s3_en && s2_valid_q) begin
      attr_fail3_q <= attr_fail2_q;
      box_out3_q   <= box_out2_q;
      dx_abs_q     <= dx_mag[CoordW-1:0];
      dy_abs_q     <= dy_mag[CoordW-1:0];
      r3_q         <= r2_q;
    end
    if (s4_en && s3_valid_q) begin
      attr_fail4_q <= attr_fail3_q;
      box_out4_q   <= box_out3_q;
      dx_sq_q      <= dx_sq_d;
      dy_sq_q      <= dy_sq_d;
      r_sq_q       <= r_sq_d;
    end
    if (s5_en && s4_valid_q) begin
      reason_q <= reason_d;
    end
  end

  assign out_valid_o     = s5_valid_q;
  assign reject_reason_o = reason_q;
  assign keep_o          = (reason_q == REASON_KEPT);

endmodule

// ===== rtl/core/point_attribute_clip_filter.sv =====
`timescale 1ns / 1ps
// point_attribute_clip_filter: top level with the register set and the pipeline
// depends on pacf_pkg and pacf_datapath

// Judges one lidar point per beat: an attribute test picked by attr_mode,
// then a rectangle or inscribed circle clip picked by clip_mode.
// Channels: input beat (pos_x, pos_y, attr_value) on in_valid_i/in_ready_o,
// result beat (keep, reject_reason) on out_valid_o/out_ready_i, and a
// register write beat (cfg_index_i, cfg_data_i) on cfg_valid_i/cfg_ready_o.
// cfg_ready_o is always high; indexes above 7 are dropped. Registers are
// meant to change only while no point is in flight.
// Throughput: one point per cycle, sustained while out_ready_i stays high, set
// by the five-stage pipeline (input capture, compares and centre offsets,
// magnitudes, squares, circle compare and verdict). The result shows on the
// output ports from the fifth register stage (the input capture is the first).
// Reset clears the register set to zero and empties the pipeline.
// When the receiver stalls each stage holds its beat; bubbles still close up,
// so up to four more points are taken before in_ready_o falls. Nothing is
// dropped or repeated.

module point_attribute_clip_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pacf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pacf_pkg::CfgDatW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           pos_x_i,
  input  logic signed [31:0]           pos_y_i,
  input  logic signed [31:0]           attr_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         keep_o,
  output logic [1:0]                   reject_reason_o
);
  import pacf_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ATTR_MODE: cfg_q.attr_mode <= attr_mode_e'(cfg_data_i[2:0]);
        CFG_BOUND_A:   cfg_q.bound_a   <= cfg_data_i;
        CFG_BOUND_B:   cfg_q.bound_b   <= cfg_data_i;
        CFG_CLIP_MODE: cfg_q.clip_mode <= clip_mode_e'(cfg_data_i[1:0]);
        CFG_CLIP_XMIN: cfg_q.clip_xmin <= cfg_data_i;
        CFG_CLIP_YMIN: cfg_q.clip_ymin <= cfg_data_i;
        CFG_CLIP_XMAX: cfg_q.clip_xmax <= cfg_data_i;
        CFG_CLIP_YMAX: cfg_q.clip_ymax <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pacf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .attr_value_i    (attr_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .keep_o          (keep_o),
    .reject_reason_o (reject_reason_o)
  );

endmodule

// ===== rtl/core/pacf_checker.sv =====
`timescale 1ns / 1ps
// pacf_checker: port-level assertions for point_attribute_clip_filter
// depends on pacf_pkg; bound to the top level at the end of this file

module pacf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_ready_o,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       keep_o,
  input logic [1:0] reject_reason_o
);
  import pacf_pkg::*;

  // a stalled result beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(keep_o) && $stable(reject_reason_o))
    else $error("result beat changed while stalled");

  // keep flag and reason agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (keep_o == (reject_reason_o == REASON_KEPT)))
    else $error("keep flag disagrees with reject reason");

  // only the three defined reasons leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reject_reason_o == REASON_KEPT || reject_reason_o == REASON_ATTR ||
                     reject_reason_o == REASON_CLIP))
    else $error("undefined reject reason");

  // with the output free the pipeline never refuses a point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o && cfg_ready_o)
    else $error("input refused while output empty");

endmodule

bind point_attribute_clip_filter pacf_checker u_pacf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_ready_o     (cfg_ready_o),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .keep_o          (keep_o),
  .reject_reason_o (reject_reason_o)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for point_attribute_clip_filter, with its own verdict predictor
// depends on pacf_pkg and the filter rtl; directed points first, then random settings and points

module tb_top;
  import pacf_pkg::*;

  localparam int unsigned HalfPeriodNs     = 6;
  localparam int unsigned ResetCycles      = 8;
  localparam int unsigned RandomSettings   = 8;
  localparam int unsigned PointsPerSetting = 56;
  localparam int unsigned SettleCycles     = 8;
  localparam longint      TimeoutNs        = 2_000_000;
  localparam longint      CoordMin         = -longint'(32'h8000_0000);
  localparam longint      CoordMax         = longint'(32'h7fff_ffff);
  localparam logic [1:0]  ClipUnused       = 2'd3;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] attr;
  } point_t;

  typedef struct {
    logic    keep;
    reason_e reason;
  } verdict_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      cfg_valid  = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index  = '0;
  logic [CfgDatW-1:0]        cfg_data   = '0;
  logic                      in_valid   = 1'b0;
  logic signed [31:0]        pos_x      = '0;
  logic signed [31:0]        pos_y      = '0;
  logic signed [31:0]        attr_value = '0;
  logic                      out_ready  = 1'b0;
  logic                      cfg_ready;
  logic                      in_ready;
  logic                      out_valid;
  logic                      keep;
  logic [1:0]                reject_reason;

  // register copies seen by the predictor
  attr_mode_e                cur_attr_mode = ATTR_NONE;
  logic signed [31:0]        cur_bound_a   = '0;
  logic signed [31:0]        cur_bound_b   = '0;
  logic [1:0]                cur_clip_mode = CLIP_NONE;
  logic signed [31:0]        cur_clip_xmin = '0;
  logic signed [31:0]        cur_clip_ymin = '0;
  logic signed [31:0]        cur_clip_xmax = '0;
  logic signed [31:0]        cur_clip_ymax = '0;

  point_t                    points_pending[$];
  verdict_t                  verdicts_due[$];
  int unsigned               points_queued  = 0;
  int unsigned               results_seen   = 0;
  int unsigned               fail_count     = 0;
  int unsigned               send_idle_pct  = 0;
  int unsigned               recv_stall_pct = 0;
  int unsigned               points_sent    = 0;
  int unsigned               points_taken   = 0;

  point_attribute_clip_filter u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .attr_value_i   (attr_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .keep_o         (keep),
    .reject_reason_o(reject_reason)
  );

  always begin
    #(HalfPeriodNs) clk = 1'b1;
    #(HalfPeriodNs) clk = 1'b0;
  end

  function automatic verdict_t judge_point(point_t p);
    verdict_t    v;
    longint      lo, hi, dx, dy, r;
    logic [63:0] adx, ady, dx2, dy2, r2;
    logic        attr_ok, clip_ok;
    case (cur_attr_mode)
      ATTR_BELOW:     attr_ok = p.attr < cur_bound_a;
      ATTR_BELOW_EQ:  attr_ok = p.attr <= cur_bound_a;
      ATTR_ABOVE:     attr_ok = p.attr > cur_bound_a;
      ATTR_ABOVE_EQ:  attr_ok = p.attr >= cur_bound_a;
      ATTR_BETWEEN: begin
        lo = (cur_bound_a < cur_bound_b) ? cur_bound_a : cur_bound_b;
        hi = (cur_bound_a < cur_bound_b) ? cur_bound_b : cur_bound_a;
        attr_ok = (p.attr >= lo) && (p.attr < hi);
      end
      ATTR_EQUAL:     attr_ok = p.attr == cur_bound_a;
      ATTR_DIFFERENT: attr_ok = p.attr != cur_bound_a;
      default:        attr_ok = 1'b1;
    endcase
    clip_ok = 1'b1;
    if (cur_clip_mode == CLIP_RECT || cur_clip_mode == CLIP_CIRCLE) begin
      if (p.x < cur_clip_xmin || p.x > cur_clip_xmax ||
          p.y < cur_clip_ymin || p.y > cur_clip_ymax) begin
        clip_ok = 1'b0;
      end else if (cur_clip_mode == CLIP_CIRCLE) begin
        // doubled units keep the centre exact; inside the box nothing overflows 64 bits
        dx  = longint'(cur_clip_xmax) + longint'(cur_clip_xmin) - 2 * longint'(p.x);
        dy  = longint'(cur_clip_ymax) + longint'(cur_clip_ymin) - 2 * longint'(p.y);
        r   = longint'(cur_clip_xmax) - longint'(cur_clip_xmin);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        dx2 = adx * adx;
        dy2 = ady * ady;
        r2  = r * r;
        clip_ok = dy2 <= r2 - dx2;
      end
    end
    if (!attr_ok) begin
      v.reason = REASON_ATTR;
    end else if (!clip_ok) begin
      v.reason = REASON_CLIP;
    end else begin
      v.reason = REASON_KEPT;
    end
    v.keep = (v.reason == REASON_KEPT);
    return v;
  endfunction

  function automatic longint pick_coord();
    case ($urandom_range(3))
      0, 1:    return longint'($urandom_range(2000)) - 1000;
      2:       return longint'($signed($urandom));
      default: return $urandom_range(1) ? CoordMax : CoordMin;
    endcase
  endfunction

  // mostly on or next to the edges of [lo, hi], sometimes anywhere
  function automatic logic signed [31:0] pick_near(longint lo, longint hi);
    longint v;
    case ($urandom_range(7))
      0:       v = longint'($signed($urandom));
      1:       v = $urandom_range(1) ? CoordMax : CoordMin;
      2, 3:    v = lo + longint'($urandom_range(2)) - 1;
      4, 5:    v = hi + longint'($urandom_range(2)) - 1;
      default: v = (lo <= hi) ? lo + (longint'($urandom) % (hi - lo + 1)) : lo;
    endcase
    if (v < CoordMin) v = CoordMin;
    if (v > CoordMax) v = CoordMax;
    return v[31:0];
  endfunction

  task automatic queue_point(longint x, longint y, longint attr);
    point_t p;
    p.x    = x[31:0];
    p.y    = y[31:0];
    p.attr = attr[31:0];
    points_pending.insert(points_pending.size(), p);
    points_queued++;
  endtask

  // sender holds off until every point handed out has come back
  task automatic wait_drained();
    wait (results_seen == points_queued);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ATTR_MODE: cur_attr_mode = attr_mode_e'(data[2:0]);
      CFG_BOUND_A:   cur_bound_a   = data;
      CFG_BOUND_B:   cur_bound_b   = data;
      CFG_CLIP_MODE: cur_clip_mode = data[1:0];
      CFG_CLIP_XMIN: cur_clip_xmin = data;
      CFG_CLIP_YMIN: cur_clip_ymin = data;
      CFG_CLIP_XMAX: cur_clip_xmax = data;
      CFG_CLIP_YMAX: cur_clip_ymax = data;
      default: ;
    endcase
  endtask

  task automatic load_setting(attr_mode_e am, longint a, longint b,
                              logic [1:0] cm, longint x0, longint y0,
                              longint x1, longint y1);
    // mode registers get junk in the unused upper bits
    write_reg(CFG_ATTR_MODE, ($urandom & ~32'h7) | 32'(am));
    write_reg(CFG_BOUND_A, a[31:0]);
    write_reg(CFG_BOUND_B, b[31:0]);
    write_reg(CFG_CLIP_MODE, ($urandom & ~32'h3) | 32'(cm));
    write_reg(CFG_CLIP_XMIN, x0[31:0]);
    write_reg(CFG_CLIP_YMIN, y0[31:0]);
    // unmapped index, must leave every register alone
    write_reg(CfgIdxW'(CFG_CLIP_YMAX) + CfgIdxW'($urandom_range(1, 8)), $urandom);
    write_reg(CFG_CLIP_XMAX, x1[31:0]);
    write_reg(CFG_CLIP_YMAX, y1[31:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a new beat goes out only once every beat driven so far has been taken
  always @(negedge clk) begin : drive_points
    point_t nxt;
    if (points_taken == points_sent) begin
      if (points_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = points_pending.pop_front();
        points_sent++;
        in_valid   <= 1'b1;
        pos_x      <= nxt.x;
        pos_y      <= nxt.y;
        attr_value <= nxt.attr;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : watch_ports
    point_t   p;
    verdict_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        p.x    = pos_x;
        p.y    = pos_y;
        p.attr = attr_value;
        verdicts_due.insert(verdicts_due.size(), judge_point(p));
        points_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (verdicts_due.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with none expected, keep %0b reason %0d",
                   $time, keep, reject_reason);
        end else begin
          want = verdicts_due.pop_front();
          if (keep !== want.keep) begin
            fail_count++;
            $display("%0t: keep mismatch, expected %0b, actual %0b",
                     $time, want.keep, keep);
          end
          if (reject_reason !== want.reason) begin
            fail_count++;
            $display("%0t: reject_reason mismatch, expected %0d, actual %0d",
                     $time, want.reason, reject_reason);
          end
        end
      end
    end
  end

  initial begin : stimulus
    longint     xa, xb, ya, yb, tmp;
    logic [1:0] cm;
    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;

    // reset setting: nothing filters
    queue_point(CoordMin, CoordMax, CoordMin);
    queue_point(CoordMax, CoordMin, CoordMax);
    wait_drained();

    // each attribute test around a = 5, b = -3
    for (int m = 1; m < 8; m++) begin
      load_setting(attr_mode_e'(m), 5, -3, CLIP_NONE, 0, 0, 0, 0);
      queue_point(0, 0, 5);
      queue_point(0, 0, -3);
      wait_drained();
    end

    // empty between range
    load_setting(ATTR_BETWEEN, 5, 5, CLIP_NONE, 0, 0, 0, 0);
    queue_point(0, 0, 5);
    wait_drained();

    // rectangle edges, and attribute failure taking precedence
    load_setting(ATTR_BELOW, 0, 0, CLIP_RECT, -10, -20, 10, 20);
    queue_point(10, 20, -1);
    queue_point(11, 0, -1);
    queue_point(0, -21, -1);
    queue_point(11, 0, 0);
    wait_drained();

    // circle: on the rim, just inside, just outside
    load_setting(ATTR_NONE, 0, 0, CLIP_CIRCLE, -10, -10, 10, 10);
    queue_point(0, 10, -1);
    queue_point(7, 7, -1);
    queue_point(8, 8, -1);
    wait_drained();

    // inverted box rejects everything
    load_setting(ATTR_NONE, 0, 0, CLIP_CIRCLE, 10, -10, -10, 10);
    queue_point(0, 0, 0);
    wait_drained();

    // spare clip code behaves as no clip
    load_setting(ATTR_NONE, 0, 0, ClipUnused, 0, 0, 0, 0);
    queue_point(CoordMax, CoordMin, 0);

    for (int s = 0; s < RandomSettings; s++) begin
      wait_drained();
      case (s % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      if (s == 0) begin
        load_setting(attr_mode_e'($urandom_range(7)), CoordMax, CoordMin, CLIP_RECT,
                     CoordMin, CoordMin, CoordMax, CoordMax);
      end else if (s == 1) begin
        load_setting(ATTR_BETWEEN, CoordMin, CoordMax, CLIP_CIRCLE,
                     CoordMin, CoordMin, CoordMax, CoordMax);
      end else begin
        xa = pick_coord();
        xb = pick_coord();
        ya = pick_coord();
        yb = pick_coord();
        if (xa > xb) begin tmp = xa; xa = xb; xb = tmp; end
        if (ya > yb) begin tmp = ya; ya = yb; yb = tmp; end
        // now and then an inverted box
        if ($urandom_range(7) == 0) begin tmp = xa; xa = xb; xb = tmp; end
        if ($urandom_range(7) == 0) begin tmp = ya; ya = yb; yb = tmp; end
        case ($urandom_range(9))
          0:          cm = CLIP_NONE;
          1:          cm = ClipUnused;
          2, 3, 4, 5: cm = CLIP_RECT;
          default:    cm = CLIP_CIRCLE;
        endcase
        load_setting(attr_mode_e'($urandom_range(7)), pick_coord(), pick_coord(), cm,
                     xa, ya, xb, yb);
      end
      for (int n = 0; n < PointsPerSetting; n++) begin
        queue_point(pick_near(cur_clip_xmin, cur_clip_xmax),
                    pick_near(cur_clip_ymin, cur_clip_ymax),
                    pick_near((cur_bound_a < cur_bound_b) ? cur_bound_a : cur_bound_b,
                              (cur_bound_a < cur_bound_b) ? cur_bound_b : cur_bound_a));
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && verdicts_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("%0t: timed out with %0d results outstanding", $time,
             points_queued - results_seen);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
